### rtl/core/bnip_pkg.sv
// package for the radix-n integer parser: widths, character codes,
// register indexes and the parser phase type
// no dependencies
`default_nettype none

package bnip_pkg;

	// alphabet and datapath sizes
	localparam int MAX_DIGITS = 16;
	localparam int SIZE_W     = 5;
	localparam int CHAR_W     = 8;
	localparam int VALUE_W    = 32;
	localparam int DIGIT_W    = $clog2(MAX_DIGITS);
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 2;

	// character codes
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_SIZE   = 2'd0,
		REG_DIGITS_LOW  = 2'd1,
		REG_DIGITS_HIGH = 2'd2
	} cfg_reg_t;

	// parser phase
	typedef enum logic [1:0] {
		PH_SPACE = 2'd0,
		PH_SIGN  = 2'd1,
		PH_DIGIT = 2'd2,
		PH_DONE  = 2'd3
	} phase_t;

	// whitespace test: tab to carriage return, and space
	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
	endfunction

	function automatic logic is_sign(input logic [CHAR_W-1:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS);
	endfunction

endpackage

`default_nettype wire

### rtl/core/bnip_char_if.sv
// character channel of the parser: valid, ready and one character
// depends on bnip_pkg
`default_nettype none

interface bnip_char_if;
	import bnip_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

### rtl/core/bnip_result_if.sv
// result channel of the parser: valid, ready, value and status flags
// depends on bnip_pkg
`default_nettype none

interface bnip_result_if;
	import bnip_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      done_res;
	logic                      base_invalid;

	modport source (output valid, output value, output done_res, output base_invalid,
		input ready);
	modport sink   (input valid, input value, input done_res, input base_invalid,
		output ready);
endinterface

`default_nettype wire

### rtl/core/base_n_integer_parser.sv
// radix-n signed integer parser, top level
// depends on bnip_pkg, bnip_char_if and bnip_result_if
//
// usage:
//  - in_ch carries one character per transaction; every character gives
//    exactly one transaction on res, in order
//  - res.value is the signed value so far, res.done_res marks the character
//    that ends the number, res.base_invalid flags an unusable alphabet
//  - the alphabet is set through the write port (cfg_en, cfg_index,
//    cfg_data): base size, digits 0 to 7, digits 8 to 15; writes must go in
//    only while no character is in flight; the block does not enforce this
//  - a character taken goes into the input register and, once res is not
//    stalled, into the result register that drives res.valid
//  - throughput: one character per cycle while res does not stall and no
//    configuration write is made; the next character uses the accumulator
//    written by the one before, a 32x5 multiply-add
//  - in_ch.ready is low in a cycle with a configuration write
//  - reset clears the configuration (alphabet reads as invalid) and puts
//    the parser back into the leading whitespace phase
//  - when res stalls the result register and the input register both
//    hold, and in_ch.ready drops once both are full
`default_nettype none

module base_n_integer_parser (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	bnip_char_if.sink                           in_ch,
	bnip_result_if.source                       res,
	input  wire logic                           cfg_en,
	input  wire logic [bnip_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bnip_pkg::CFG_W-1:0]     cfg_data
);
	import bnip_pkg::*;

	// configuration registers
	logic [SIZE_W-1:0]          base_size_q;
	logic [CFG_W-1:0]           digits_low_q;
	logic [CFG_W-1:0]           digits_high_q;
	logic                       bad_q;

	// input register
	logic                       valid_s1;
	logic [CHAR_W-1:0]          ch_s1;

	// parser state
	phase_t                     phase_q;
	phase_t                     phase_d;
	logic                       neg_q;
	logic                       neg_d;
	logic [VALUE_W-1:0]         accum_q;
	logic [VALUE_W-1:0]         accum_d;

	// result register
	logic                       res_valid_q;
	logic signed [VALUE_W-1:0]  res_value_q;
	logic                       res_done_q;
	logic                       res_bad_q;

	// step logic
	logic                       fire;
	logic                       in_take;
	logic [SIZE_W-1:0]          eff_size;
	logic [2*CFG_W-1:0]         alpha_bits;
	logic                       bad_d;
	logic                       hit;
	logic [DIGIT_W-1:0]         digit;
	logic                       ends;
	logic [VALUE_W-1:0]         out_mag;
	logic                       out_neg;
	logic                       out_done;

	// handshake
	assign fire        = valid_s1 && (!res_valid_q || res.ready);
	assign in_ch.ready = (!valid_s1 || fire) && !cfg_en;
	assign in_take     = in_ch.valid && in_ch.ready;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_size_q   <= '0;
			digits_low_q  <= '0;
			digits_high_q <= '0;
		end else if (cfg_en) begin
			unique case (cfg_index)
				REG_BASE_SIZE:   base_size_q   <= cfg_data[SIZE_W-1:0];
				REG_DIGITS_LOW:  digits_low_q  <= cfg_data;
				REG_DIGITS_HIGH: digits_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// radix saturates at the alphabet capacity
	assign eff_size   = (base_size_q > SIZE_W'(MAX_DIGITS)) ? SIZE_W'(MAX_DIGITS)
		: base_size_q;
	assign alpha_bits = {digits_high_q, digits_low_q};

	// alphabet check: too short, forbidden character or repeated character
	always_comb begin
		bad_d = (eff_size < SIZE_W'(2));
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (SIZE_W'(i) < eff_size) begin
				if ((alpha_bits[8*i +: 8] == CH_NUL) || is_sign(alpha_bits[8*i +: 8])
					|| is_space(alpha_bits[8*i +: 8])) begin
					bad_d = 1'b1;
				end
				for (int j = i + 1; j < MAX_DIGITS; j++) begin
					if ((SIZE_W'(j) < eff_size)
						&& (alpha_bits[8*j +: 8] == alpha_bits[8*i +: 8])) begin
						bad_d = 1'b1;
					end
				end
			end
		end
	end

	// alphabet flag, registered from the check of the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q <= 1'b1;
		end else begin
			bad_q <= bad_d;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			ch_s1 <= in_ch.ch;
		end
	end

	// digit lookup, first matching position wins
	always_comb begin
		hit   = 1'b0;
		digit = '0;
		for (int k = MAX_DIGITS - 1; k >= 0; k--) begin
			if ((SIZE_W'(k) < eff_size) && (alpha_bits[8*k +: 8] == ch_s1)) begin
				hit   = 1'b1;
				digit = DIGIT_W'(k);
			end
		end
	end

	// next state and result of one character
	always_comb begin
		phase_d  = phase_q;
		neg_d    = neg_q;
		accum_d  = accum_q;
		ends     = 1'b0;
		out_mag  = accum_q;
		out_neg  = neg_q;
		out_done = 1'b0;
		if (ch_s1 == CH_NUL) begin
			out_done = (phase_q != PH_DONE);
			phase_d  = PH_SPACE;
			neg_d    = 1'b0;
			accum_d  = '0;
		end else begin
			if (phase_q != PH_DONE) begin
				if (is_space(ch_s1)) begin
					ends = (phase_q != PH_SPACE);
				end else if (is_sign(ch_s1)) begin
					if (phase_q == PH_DIGIT) begin
						ends = 1'b1;
					end else begin
						phase_d = PH_SIGN;
						if (ch_s1 == CH_MINUS) begin
							neg_d = !neg_q;
						end
					end
				end else if (hit) begin
					phase_d = PH_DIGIT;
					accum_d = accum_q * VALUE_W'(eff_size) + VALUE_W'(digit);
				end else begin
					ends = 1'b1;
				end
				if (ends) begin
					phase_d = PH_DONE;
				end
			end
			out_mag  = accum_d;
			out_neg  = neg_d;
			out_done = ends;
		end
	end

	// parser state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			accum_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			accum_q <= accum_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_value_q <= $signed(out_neg ? (-out_mag) : out_mag);
			res_done_q  <= out_done;
			res_bad_q   <= bad_q;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.value        = res_value_q;
	assign res.done_res     = res_done_q;
	assign res.base_invalid = res_bad_q;

	// a finished number keeps its magnitude until a terminating nul
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (phase_q == PH_DONE) && (ch_s1 != CH_NUL)) |=> $stable(accum_q))
		else $error("accumulator changed after the number ended");

	// a nul returns the parser to its reset state
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && (ch_s1 == CH_NUL)) |=> ((phase_q == PH_SPACE) && !neg_q && (accum_q == '0)))
		else $error("parser state not cleared by nul");

	// no new character while both registers are held by a stalled receiver
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && res_valid_q && !res.ready) |-> !in_ch.ready)
		else $error("input accepted while pipeline is full and stalled");

endmodule

`default_nettype wire
